FILE: hw/rtl/printable_string_run_finder_core_defines.svh
// assertion macros shared by the run finder modules
`ifndef PRINTABLE_STRING_RUN_FINDER_CORE_DEFINES_SVH
`define PRINTABLE_STRING_RUN_FINDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PSRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/psrf_pkg.sv
// shared types and constants for the printable run finder
package psrf_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int OUT_BITS = 32;
    localparam logic [7:0] DEFAULT_MIN_LENGTH = 8'd4;
    localparam logic [7:0] RESET_MIN_LENGTH = 8'd4;
    localparam logic [7:0] PRINT_LOW = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] ofs_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] run_start;
        logic [OUT_BITS-1:0] run_end;
        logic run_wide;
        logic last_result;
    } result_t;

    // up to two results produced by one byte, narrow one first
    typedef struct packed {
        logic [1:0] count;
        result_t first;
        result_t second;
    } push_t;

endpackage

FILE: hw/rtl/printable_string_run_finder_core.sv
// top level of the printable run finder: scan stage feeding a result queue
//
// usage:
// - input channel in_valid/in_ready carries one word per stream byte:
//   cur_byte, the following byte next_byte and next_valid; offsets count
//   from zero at reset, one per accepted word
// - output channel out_valid/out_ready carries run reports: run_start,
//   run_end, run_wide and last_result, which marks the final report of
//   the byte that caused it; a byte gives zero, one or two reports
// - cfg_valid/cfg_ready writes min_length (zero means four); cfg_ready is
//   always high, write only while no word is in flight
// - a word is registered at acceptance and its reports enter the queue
//   once there is room for a pair; out_valid comes from the queue count
// - throughput: one byte per cycle while the queue has room for a pair;
//   bytes closing runs are limited by the output port at one report per
//   cycle, the four-entry queue absorbing a pair per byte
// - reset clears offsets, open runs and the queue, min_length returns to 4
// - when the receiver stalls, reports wait in the queue and in_ready drops
//   once fewer than two entries are free; runs still open are not reported
module printable_string_run_finder_core (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] cur_byte,
    input  logic [7:0] next_byte,
    input  logic next_valid,
    output logic out_valid,
    input  logic out_ready,
    output logic [31:0] run_start,
    output logic [31:0] run_end,
    output logic run_wide,
    output logic last_result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [7:0] cfg_data
);

    psrf_pkg::push_t push;
    psrf_pkg::result_t head;
    logic space;

    assign cfg_ready = 1'b1;

    psrf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cur_byte  (cur_byte),
        .next_byte (next_byte),
        .next_valid(next_valid),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .space     (space),
        .push      (push)
    );

    psrf_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space    (space),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .head     (head)
    );

    assign run_start = head.run_start;
    assign run_end = head.run_end;
    assign run_wide = head.run_wide;
    assign last_result = head.last_result;

endmodule

FILE: hw/rtl/psrf_scan.sv
// input register, run tracking state and result generation
`include "printable_string_run_finder_core_defines.svh"

module psrf_scan (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] cur_byte,
    input  logic [7:0] next_byte,
    input  logic next_valid,
    input  logic cfg_valid,
    input  logic [7:0] cfg_data,
    input  logic space,
    output psrf_pkg::push_t push
);

    logic in_valid_reg, in_valid_next;
    logic [7:0] cur_reg, nxt_reg;
    logic nv_reg;
    logic [7:0] min_length_reg;

    psrf_pkg::ofs_t offset_reg, offset_next;
    psrf_pkg::ofs_t narrow_start_reg, narrow_start_next;
    psrf_pkg::ofs_t odd_start_reg, odd_start_next;
    psrf_pkg::ofs_t even_start_reg, even_start_next;
    logic narrow_open_reg, narrow_open_next;
    logic odd_open_reg, odd_open_next;
    logic even_open_reg, even_open_next;

    logic advance;
    logic [7:0] need;
    logic nprint, wprint, odd;
    psrf_pkg::ofs_t narrow_dist, wide_dist, wide_start;
    logic wide_open;
    logic narrow_hit, wide_hit;
    psrf_pkg::result_t narrow_res, wide_res;

    assign advance = in_valid_reg && space;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        need = (min_length_reg == 8'd0) ? psrf_pkg::DEFAULT_MIN_LENGTH : min_length_reg;
        nprint = (cur_reg >= psrf_pkg::PRINT_LOW) && (cur_reg <= psrf_pkg::PRINT_HIGH);
        // wide char is printable only with a zero high byte
        wprint = nv_reg && (nxt_reg == 8'd0) && nprint;
        odd = offset_reg[0];
        wide_start = odd ? odd_start_reg : even_start_reg;
        wide_open = odd ? odd_open_reg : even_open_reg;
        narrow_dist = offset_reg - narrow_start_reg;
        wide_dist = offset_reg - wide_start;

        narrow_hit = !nprint && narrow_open_reg
            && (narrow_dist >= psrf_pkg::OFFSET_BITS'(need));
        wide_hit = !wprint && wide_open
            && ((wide_dist >> 1) >= psrf_pkg::OFFSET_BITS'(need));

        narrow_start_next = narrow_start_reg;
        narrow_open_next = narrow_open_reg;
        if (nprint)
        begin
            if (!narrow_open_reg)
            begin
                narrow_open_next = 1'b1;
                narrow_start_next = offset_reg;
            end
        end
        else
        begin
            narrow_open_next = 1'b0;
        end

        odd_start_next = odd_start_reg;
        odd_open_next = odd_open_reg;
        even_start_next = even_start_reg;
        even_open_next = even_open_reg;
        if (odd)
        begin
            if (wprint && !odd_open_reg)
            begin
                odd_open_next = 1'b1;
                odd_start_next = offset_reg;
            end
            else if (!wprint)
            begin
                odd_open_next = 1'b0;
            end
        end
        else
        begin
            if (wprint && !even_open_reg)
            begin
                even_open_next = 1'b1;
                even_start_next = offset_reg;
            end
            else if (!wprint)
            begin
                even_open_next = 1'b0;
            end
        end

        offset_next = offset_reg + psrf_pkg::OFFSET_BITS'(1);
    end

    always_comb
    begin
        narrow_res.run_start = psrf_pkg::OUT_BITS'(narrow_start_reg);
        narrow_res.run_end = psrf_pkg::OUT_BITS'(offset_reg);
        narrow_res.run_wide = 1'b0;
        narrow_res.last_result = !wide_hit;

        wide_res.run_start = psrf_pkg::OUT_BITS'(wide_start);
        wide_res.run_end = psrf_pkg::OUT_BITS'(offset_reg);
        wide_res.run_wide = 1'b1;
        wide_res.last_result = 1'b1;

        push.count = 2'd0;
        push.first = narrow_hit ? narrow_res : wide_res;
        push.second = wide_res;
        if (advance)
        begin
            push.count = {1'b0, narrow_hit} + {1'b0, wide_hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            min_length_reg <= psrf_pkg::RESET_MIN_LENGTH;
            offset_reg <= '0;
            narrow_start_reg <= '0;
            odd_start_reg <= '0;
            even_start_reg <= '0;
            narrow_open_reg <= 1'b0;
            odd_open_reg <= 1'b0;
            even_open_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid)
            begin
                min_length_reg <= cfg_data;
            end
            if (advance)
            begin
                offset_reg <= offset_next;
                narrow_start_reg <= narrow_start_next;
                odd_start_reg <= odd_start_next;
                even_start_reg <= even_start_next;
                narrow_open_reg <= narrow_open_next;
                odd_open_reg <= odd_open_next;
                even_open_reg <= even_open_next;
            end
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cur_reg <= cur_byte;
            nxt_reg <= next_byte;
            nv_reg <= next_valid;
        end
    end

    `PSRF_ASSERT_NXT(a_offset_step, advance,
        offset_reg == $past(offset_reg) + psrf_pkg::OFFSET_BITS'(1),
        "byte offset did not advance by one")
    `PSRF_ASSERT_NOW(a_no_push_without_word, !advance, push.count == 2'd0,
        "results pushed without a word in process")

endmodule

FILE: hw/rtl/psrf_result_fifo.sv
// small result queue taking up to two results per cycle, giving one
`include "printable_string_run_finder_core_defines.svh"

module psrf_result_fifo (
    input  logic clk,
    input  logic rst_n,
    input  psrf_pkg::push_t push,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output psrf_pkg::result_t head
);

    psrf_pkg::result_t mem [psrf_pkg::FIFO_DEPTH];
    logic [psrf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psrf_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psrf_pkg::FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [psrf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_plus1;
    logic pop;

    assign out_valid = (count_reg != '0);
    assign pop = out_valid && out_ready;
    // room for a full pair of results
    assign space = (count_reg <= psrf_pkg::FIFO_CNT_BITS'(psrf_pkg::FIFO_DEPTH - 2));
    assign head = mem[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + psrf_pkg::FIFO_PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + psrf_pkg::FIFO_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + psrf_pkg::FIFO_PTR_BITS'(pop);
        count_next = count_reg + psrf_pkg::FIFO_CNT_BITS'(push.count)
            - psrf_pkg::FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    `PSRF_ASSERT_NOW(a_no_overflow, push.count != 2'd0, space,
        "result queue written without room")
    `PSRF_ASSERT_NOW(a_pair_order, push.count == 2'd2,
        !push.first.last_result && push.second.last_result && !push.first.run_wide,
        "result pair has wrong order or last marks")

endmodule

FILE: sim/testbench.sv
// testbench for the printable run finder: byte stream stimulus, run predictor, report checks
module testbench;

    localparam logic RUN_NARROW = 1'b0;
    localparam logic RUN_WIDE = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 80;

    // tracks the three open runs and holds the reports they will produce
    class run_tracker;
        logic [7:0] min_len = psrf_pkg::RESET_MIN_LENGTH;
        psrf_pkg::ofs_t byte_ofs = '0;
        psrf_pkg::ofs_t narrow_start = '0;
        logic narrow_open = 1'b0;
        psrf_pkg::ofs_t odd_start = '0;
        logic odd_open = 1'b0;
        psrf_pkg::ofs_t even_start = '0;
        logic even_open = 1'b0;
        psrf_pkg::result_t reports_due[$];
        int errors = 0;

        function void set_min_length(input logic [7:0] value);
            min_len = value;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function psrf_pkg::result_t make_report(input psrf_pkg::ofs_t start_ofs,
                                                input psrf_pkg::ofs_t stop_ofs,
                                                input logic wide);
            psrf_pkg::result_t r;
            r.run_start = psrf_pkg::OUT_BITS'(start_ofs);
            r.run_end = psrf_pkg::OUT_BITS'(stop_ofs);
            r.run_wide = wide;
            r.last_result = 1'b0;
            return r;
        endfunction

        // one stream byte: update the runs and queue the reports it closes
        function void note_byte(input logic [7:0] cur, input logic [7:0] nxt,
                                input logic nxt_ok);
            psrf_pkg::ofs_t need;
            psrf_pkg::ofs_t span;
            logic [15:0] wch;
            logic narrow_ok;
            logic wide_ok;
            psrf_pkg::result_t fresh[2];
            int cnt;
            need = (min_len == 8'd0) ? psrf_pkg::ofs_t'(psrf_pkg::DEFAULT_MIN_LENGTH)
                                     : psrf_pkg::ofs_t'(min_len);
            wch = nxt_ok ? {nxt, cur} : 16'h0000;
            narrow_ok = (cur >= psrf_pkg::PRINT_LOW) && (cur <= psrf_pkg::PRINT_HIGH);
            wide_ok = (wch >= {8'h00, psrf_pkg::PRINT_LOW})
                && (wch <= {8'h00, psrf_pkg::PRINT_HIGH});
            cnt = 0;

            if (narrow_ok)
            begin
                if (!narrow_open)
                begin
                    narrow_open = 1'b1;
                    narrow_start = byte_ofs;
                end
            end
            else if (narrow_open)
            begin
                span = byte_ofs - narrow_start;
                if (span >= need)
                begin
                    fresh[cnt] = make_report(narrow_start, byte_ofs, RUN_NARROW);
                    cnt++;
                end
                narrow_open = 1'b0;
            end

            // a wide character closes only the run of the current parity
            if (wide_ok)
            begin
                if (byte_ofs[0])
                begin
                    if (!odd_open)
                    begin
                        odd_open = 1'b1;
                        odd_start = byte_ofs;
                    end
                end
                else if (!even_open)
                begin
                    even_open = 1'b1;
                    even_start = byte_ofs;
                end
            end
            else if (byte_ofs[0])
            begin
                if (odd_open)
                begin
                    span = byte_ofs - odd_start;
                    if ((span >> 1) >= need)
                    begin
                        fresh[cnt] = make_report(odd_start, byte_ofs, RUN_WIDE);
                        cnt++;
                    end
                    odd_open = 1'b0;
                end
            end
            else if (even_open)
            begin
                span = byte_ofs - even_start;
                if ((span >> 1) >= need)
                begin
                    fresh[cnt] = make_report(even_start, byte_ofs, RUN_WIDE);
                    cnt++;
                end
                even_open = 1'b0;
            end

            if (cnt > 0)
                fresh[cnt - 1].last_result = 1'b1;
            for (int i = 0; i < cnt; i++)
                reports_due.push_back(fresh[i]);
            byte_ofs = byte_ofs + 1'b1;
        endfunction

        function void check_report(input psrf_pkg::result_t got);
            psrf_pkg::result_t want;
            if (reports_due.size() == 0)
            begin
                $error("unexpected report start %0h end %0h", got.run_start, got.run_end);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            if (got.run_start !== want.run_start)
            begin
                $error("run_start expected %0h got %0h", want.run_start, got.run_start);
                errors++;
            end
            if (got.run_end !== want.run_end)
            begin
                $error("run_end expected %0h got %0h", want.run_end, got.run_end);
                errors++;
            end
            if (got.run_wide !== want.run_wide)
            begin
                $error("run_wide expected %0b got %0b", want.run_wide, got.run_wide);
                errors++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result expected %0b got %0b", want.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] cur_byte = 8'h00;
    logic [7:0] next_byte = 8'h00;
    logic next_valid = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] run_start;
    logic [31:0] run_end;
    logic run_wide;
    logic last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = 8'h00;

    run_tracker tracker = new;
    logic [7:0] stream_q[$];
    logic no_idle = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    printable_string_run_finder_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cur_byte(cur_byte),
        .next_byte(next_byte),
        .next_valid(next_valid),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .run_start(run_start),
        .run_end(run_end),
        .run_wide(run_wide),
        .last_result(last_result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // report side: random stalls plus one long hold-off to fill the queue
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_report('{run_start: run_start, run_end: run_end,
                                   run_wide: run_wide, last_result: last_result});
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else
            out_ready <= no_idle || ($urandom_range(99) >= 17);
    end

    task automatic send_byte(input logic [7:0] cur, input logic [7:0] nxt, input logic nxt_ok);
        if (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cur_byte <= cur;
        next_byte <= nxt;
        next_valid <= nxt_ok;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_byte(cur, nxt, nxt_ok);
    endtask

    // drain all reports, let bytes without reports clear the pipe, then write
    task automatic write_min_length(input logic [7:0] value);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_min_length(value);
        cfg_valid <= 1'b0;
    endtask

    function automatic void append_text(input int len);
        repeat (len)
            stream_q.push_back(8'($urandom_range(psrf_pkg::PRINT_LOW, psrf_pkg::PRINT_HIGH)));
    endfunction

    // utf-16le text, now and then a char with a nonzero high byte
    function automatic void append_wide(input int len);
        repeat (len)
        begin
            stream_q.push_back(8'($urandom_range(psrf_pkg::PRINT_LOW, psrf_pkg::PRINT_HIGH)));
            stream_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        end
    endfunction

    function automatic void append_ctrl(input int len);
        repeat (len)
            stream_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                           : 8'($urandom_range(127, 255)));
    endfunction

    function automatic void append_noise(input int len);
        repeat (len) stream_q.push_back(8'($urandom));
    endfunction

    function automatic void add_segment();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        if (kind < 4)
            append_text(len);
        else if (kind < 7)
            append_wide(len);
        else if (kind == 7)
            append_noise(len);
        else
            append_ctrl($urandom_range(1, 3));
    endfunction

    // feed the stream one byte per word, next_byte taken from the stream itself
    task automatic play_stream(input int count);
        logic [7:0] cur;
        logic [7:0] nxt;
        logic nxt_ok;
        while (stream_q.size() < count + 1) add_segment();
        repeat (count)
        begin
            cur = stream_q.pop_front();
            nxt = stream_q[0];
            nxt_ok = 1'b1;
            if ($urandom_range(99) < 6)
                nxt_ok = 1'b0;
            else if ($urandom_range(99) < 5)
                nxt = 8'($urandom);
            send_byte(cur, nxt, nxt_ok);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // narrow run from offset zero with both printable bounds, closed by 0x7f
        send_byte(psrf_pkg::PRINT_LOW, 8'h00, 1'b1);
        send_byte(psrf_pkg::PRINT_HIGH, 8'h00, 1'b1);
        send_byte(8'h41, 8'h00, 1'b1);
        send_byte(8'h42, 8'h00, 1'b1);
        send_byte(8'h7F, 8'h00, 1'b1);
        // both wide parities open alongside a narrow run
        for (int i = 0; i < 8; i++)
            send_byte(8'h61 + 8'(i), 8'h00, 1'b1);
        // narrow and odd wide close on the same byte, then even wide
        send_byte(8'h1F, 8'h00, 1'b1);
        send_byte(8'hFF, 8'hFF, 1'b1);
        // no following byte: wide char reads as zero
        send_byte(8'h78, 8'h00, 1'b0);
        send_byte(psrf_pkg::PRINT_HIGH, 8'h01, 1'b1);
        send_byte(8'h80, 8'h00, 1'b1);
        send_byte(8'h00, psrf_pkg::PRINT_HIGH, 1'b0);
        send_byte(8'h20, 8'h00, 1'b1);

        write_min_length(8'd1);
        hold_go = 1'b1;
        play_stream(150);

        write_min_length(8'd0);
        play_stream(150);

        // longest minimum: narrow runs just under, at and over the limit
        write_min_length(8'd255);
        append_ctrl(1);
        append_text(254);
        append_ctrl(1);
        append_text(255);
        append_ctrl(1);
        append_text(260);
        append_ctrl(2);
        play_stream(stream_q.size());

        write_min_length(8'd2);
        no_idle = 1'b1;
        play_stream(200);
        no_idle = 1'b0;

        write_min_length(8'd3);
        play_stream(150);

        write_min_length(8'($urandom_range(5, 12)));
        play_stream(150);

        write_min_length(8'd4);
        play_stream(150);

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
